// ----- sv/fdnm_pkg.sv -----
// ----------------------------------------------------------------------------
// fdnm_pkg
// Types, codes and helpers shared by the directory name matcher modules.
// ----------------------------------------------------------------------------
package fdnm_pkg;

  localparam int TARGET_DEPTH_DEF    = 128;
  localparam int LONG_NAME_DEPTH_DEF = 256;

  localparam logic [7:0]  ENTRY_END     = 8'h00;
  localparam logic [7:0]  ENTRY_DELETED = 8'hE5;
  localparam logic [7:0]  ATTR_LFN      = 8'h0F;
  localparam logic [4:0]  ORDER_MASK    = 5'h1F;
  localparam int          ORDER_LAST    = 6;      // bit 0x40 of the order byte
  localparam logic [15:0] CHAR_UNUSED   = 16'hFFFF;
  localparam logic [15:0] ASCII_LIMIT   = 16'h0080;
  localparam int          LFN_CHARS     = 13;
  localparam logic [7:0]  CHAR_SPACE    = 8'h20;
  localparam logic [7:0]  CHAR_DOT      = 8'h2E;
  localparam logic [7:0]  CHAR_QMARK    = 8'h3F;

  typedef enum logic [1:0] {
    KIND_SHORT   = 2'd0,
    KIND_LONG    = 2'd1,
    KIND_DELETED = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_SKIP     = 2'd0,
    STAT_NO_MATCH = 2'd1,
    STAT_MATCH    = 2'd2,
    STAT_END      = 2'd3
  } status_t;

  typedef struct packed {
    kind_t            kind;
    logic [31:0][7:0] bytes;
  } entry_t;

  typedef struct packed {
    logic       start;   // new scan: clear long name and end flag
    logic       twe;
    logic [7:0] taddr;
    logic [7:0] tdata;
  } front_ctl_t;

  typedef struct packed {
    logic done;
    logic finished;
  } back_sts_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // byte offset of long-name character i inside the entry
  function automatic logic [4:0] lfn_offset(input logic [3:0] i);
    if (i < 4'd5) begin
      return 5'd1 + {i[3:0], 1'b0};
    end else if (i < 4'd11) begin
      return 5'd14 + {i - 4'd5, 1'b0};
    end
    return 5'd28 + {i - 4'd11, 1'b0};
  endfunction

endpackage

// ----- sv/fdnm_ram.sv -----
// ----------------------------------------------------------------------------
// fdnm_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fdnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/fdnm_fifo.sv -----
// ----------------------------------------------------------------------------
// fdnm_fifo
// Two-entry queue carrying completed entries from front to back.
// ----------------------------------------------------------------------------
module fdnm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      slot[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && push_ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && pop_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'((push && push_ready) ? 1 : 0) - 2'((pop && pop_valid) ? 1 : 0);
    end
  end

endmodule

// ----- sv/fdnm_front.sv -----
// ----------------------------------------------------------------------------
// fdnm_front
// Accepts requests, loads the target name, collects and classifies entries.
// ----------------------------------------------------------------------------
module fdnm_front import fdnm_pkg::*; #(
  parameter int TARGET_DEPTH = TARGET_DEPTH_DEF,
  parameter int TLW          = $clog2(TARGET_DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,
  input  logic [1:0]     s_tuser,
  output front_ctl_t     ctl,
  input  back_sts_t      sts,
  output logic           push,
  output entry_t         push_entry,
  input  logic           push_ready,
  output logic [TLW-1:0] tlen
);

  logic             pending;
  logic [4:0]       pos;
  logic [31:0][7:0] eb;
  logic             accept;
  logic             cmd;
  logic             first;
  logic             take;
  logic             room;

  assign cmd      = s_tuser[0];
  assign first    = s_tuser[1];
  assign s_tready = !pending && push_ready;
  assign accept   = s_tvalid && s_tready;
  assign room     = (tlen < TLW'(TARGET_DEPTH));
  // drop directory bytes after end or match until a new scan
  assign take     = accept && cmd && (first || !sts.finished);
  assign push     = take && !first && (pos == 5'd31);

  always_comb begin
    ctl.start = accept && cmd && first;
    ctl.twe   = accept && !cmd && (first || room);
    ctl.taddr = first ? 8'd0 : 8'(tlen);
    ctl.tdata = s_tdata;
  end

  always_comb begin
    push_entry.bytes     = eb;
    push_entry.bytes[31] = s_tdata;
    if (push_entry.bytes[0] == ENTRY_END) begin
      push_entry.kind = KIND_END;
    end else if (push_entry.bytes[0] == ENTRY_DELETED) begin
      push_entry.kind = KIND_DELETED;
    end else if (push_entry.bytes[11] == ATTR_LFN) begin
      push_entry.kind = KIND_LONG;
    end else begin
      push_entry.kind = KIND_SHORT;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (first) begin
        eb[0] <= s_tdata;
      end else begin
        eb[pos] <= s_tdata;
      end
    end
    if (rst) begin
      pending <= 1'b0;
      pos     <= 5'd0;
      tlen    <= '0;
    end else begin
      if (push) begin
        pending <= 1'b1;
      end else if (sts.done) begin
        pending <= 1'b0;
      end
      if (take) begin
        pos <= first ? 5'd1 : pos + 5'd1;
      end
      if (accept && !cmd) begin
        if (first) begin
          tlen <= TLW'(1);
        end else if (room) begin
          tlen <= tlen + TLW'(1);
        end
      end
    end
  end

endmodule

// ----- sv/fdnm_back.sv -----
// ----------------------------------------------------------------------------
// fdnm_back
// Carries out entries: long-name store updates, name compare, result output.
// ----------------------------------------------------------------------------
module fdnm_back import fdnm_pkg::*; #(
  parameter int TARGET_DEPTH    = TARGET_DEPTH_DEF,
  parameter int LONG_NAME_DEPTH = LONG_NAME_DEPTH_DEF,
  parameter int TLW             = $clog2(TARGET_DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  front_ctl_t     ctl,
  output back_sts_t      sts,
  input  logic           fifo_valid,
  input  entry_t         fifo_entry,
  output logic           pop,
  input  logic [TLW-1:0] tlen,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [79:0]    m_tdata
);

  localparam int TAW = $clog2(TARGET_DEPTH);
  localparam int LAW = $clog2(LONG_NAME_DEPTH);
  localparam int CW  = (LAW > TLW) ? LAW + 1 : TLW + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LFN  = 5'b00010,
    S_ADDR = 5'b00100,
    S_DATA = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t                 state;
  logic [31:0][7:0]       e;
  logic [3:0]             ci;
  logic [8:0]             base;
  logic [LAW-1:0]         k;
  logic                   long_mode;
  status_t                res_status;
  logic                   res_full;
  logic                   finished;
  logic [LONG_NAME_DEPTH-1:0] lvalid;
  logic                   sv_q;
  logic                   tin_q;
  logic                   lclr;
  logic                   lw;
  logic [8:0]             lpos;
  logic [7:0]             lwdata;
  logic [7:0]             lrd;
  logic [7:0]             trd;
  logic [15:0]            ch;
  logic [4:0]             at;
  logic                   can_load;
  logic [7:0]             text [16];
  logic [7:0]             s_ch;
  logic [7:0]             t_ch;
  logic [3:0]             nl;
  logic [3:0]             el;
  logic                   ext;
  logic [4:0]             order;

  fdnm_ram #(.WIDTH(8), .DEPTH(LONG_NAME_DEPTH)) u_lram (
    .clk  (clk),
    .we   (lw),
    .waddr(lpos[LAW-1:0]),
    .wdata(lwdata),
    .raddr(k),
    .rdata(lrd)
  );

  fdnm_ram #(.WIDTH(8), .DEPTH(TARGET_DEPTH)) u_tram (
    .clk  (clk),
    .we   (ctl.twe),
    .waddr(ctl.taddr[TAW-1:0]),
    .wdata(ctl.tdata),
    .raddr(k[TAW-1:0]),
    .rdata(trd)
  );

  assign can_load     = !m_tvalid || m_tready;
  assign sts.done     = (state == S_FIN) && can_load;
  assign sts.finished = finished;
  assign pop          = (state == S_IDLE) && fifo_valid;
  assign order        = fifo_entry.bytes[0][4:0] & ORDER_MASK;

  // long-name character for the current step
  always_comb begin
    at     = lfn_offset(ci);
    ch     = {e[at + 5'd1], e[at]};
    lpos   = base + 9'(ci);
    lwdata = (ch < ASCII_LIMIT) ? ch[7:0] : CHAR_QMARK;
    lw     = (state == S_LFN) && (ch != 16'h0000) && (ch != CHAR_UNUSED) &&
             ({1'b0, lpos} < 10'(LONG_NAME_DEPTH - 1));
  end

  // 8.3 text, one position at a time
  always_comb begin
    nl = 4'd8;
    for (int j = 7; j >= 0; j--) begin
      if (e[j] == CHAR_SPACE) begin
        nl = 4'(j);
      end
    end
    el = 4'd3;
    for (int j = 2; j >= 0; j--) begin
      if (e[8 + j] == CHAR_SPACE) begin
        el = 4'(j);
      end
    end
    ext = (e[8] != CHAR_SPACE);
    for (int j = 0; j < 16; j++) begin
      if (4'(j) < nl) begin
        text[j] = e[j];
      end else if (ext && 4'(j) == nl) begin
        text[j] = CHAR_DOT;
      end else if (ext && 4'(j) > nl && (4'(j) - nl - 4'd1) < el) begin
        text[j] = e[5'd8 + 5'(4'(j) - nl - 4'd1)];
      end else begin
        text[j] = 8'd0;
      end
    end
  end

  always_comb begin
    s_ch = long_mode ? (sv_q ? lrd : 8'd0) : text[k[3:0]];
    t_ch = tin_q ? trd : 8'd0;
  end

  always_comb begin
    lclr = 1'b0;
    if (state == S_IDLE && fifo_valid) begin
      lclr = (fifo_entry.kind == KIND_DELETED) ||
             (fifo_entry.kind == KIND_LONG && fifo_entry.bytes[0][ORDER_LAST]);
    end else if (state == S_DATA && !long_mode && !(s_ch == 8'd0 && t_ch == 8'd0) &&
                 fold_case(s_ch) != fold_case(t_ch)) begin
      lclr = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e <= fifo_entry.bytes;
    end
    if (state == S_ADDR) begin
      sv_q  <= lvalid[k];
      tin_q <= (CW'(k) < CW'(tlen));
    end
    if (state == S_FIN && can_load) begin
      m_tdata <= {6'd0,
                  res_full ? {e[31], e[30], e[29], e[28]} : 32'd0,
                  res_full ? {e[21], e[20], e[27], e[26]} : 32'd0,
                  res_full ? e[11] : 8'd0,
                  res_status};
    end
    if (rst) begin
      state      <= S_IDLE;
      finished   <= 1'b0;
      lvalid     <= '0;
      m_tvalid   <= 1'b0;
      ci         <= 4'd0;
      base       <= 9'd0;
      k          <= '0;
      long_mode  <= 1'b0;
      res_status <= STAT_SKIP;
      res_full   <= 1'b0;
    end else begin
      if (ctl.start || lclr) begin
        lvalid <= '0;
      end else if (lw) begin
        lvalid[lpos[LAW-1:0]] <= 1'b1;
      end
      if (ctl.start) begin
        finished <= 1'b0;
      end
      if (state == S_FIN && can_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (fifo_valid) begin
            res_status <= STAT_SKIP;
            res_full   <= 1'b0;
            case (fifo_entry.kind)
              KIND_END: begin
                res_status <= STAT_END;
                finished   <= 1'b1;
                state      <= S_FIN;
              end
              KIND_DELETED: begin
                state <= S_FIN;
              end
              KIND_LONG: begin
                ci    <= 4'd0;
                base  <= 9'(({4'd0, order} - 9'd1) * 9'(LFN_CHARS));
                state <= (order == 5'd0) ? S_FIN : S_LFN;
              end
              default: begin
                res_full  <= 1'b1;
                long_mode <= 1'b1;
                k         <= '0;
                state     <= S_ADDR;
              end
            endcase
          end
        end
        S_LFN: begin
          if (ch == 16'h0000 || ch == CHAR_UNUSED || ci == 4'(LFN_CHARS - 1)) begin
            state <= S_FIN;
          end else begin
            ci <= ci + 4'd1;
          end
        end
        S_ADDR: begin
          state <= S_DATA;
        end
        S_DATA: begin
          if (long_mode && k == '0 && s_ch == 8'd0) begin
            // empty long name: go straight to the short name
            long_mode <= 1'b0;
            state     <= S_ADDR;
          end else if (s_ch == 8'd0 && t_ch == 8'd0) begin
            res_status <= STAT_MATCH;
            finished   <= 1'b1;
            state      <= S_FIN;
          end else if (fold_case(s_ch) != fold_case(t_ch)) begin
            if (long_mode) begin
              long_mode <= 1'b0;
              k         <= '0;
              state     <= S_ADDR;
            end else begin
              res_status <= STAT_NO_MATCH;
              state      <= S_FIN;
            end
          end else begin
            k     <= k + LAW'(1);
            state <= S_ADDR;
          end
        end
        S_FIN: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/fat_directory_name_match.sv -----
// ----------------------------------------------------------------------------
// fat_directory_name_match
// Looks up one target name in a stream of 32-byte FAT directory entries.
// ----------------------------------------------------------------------------
// Input stream: each request carries one byte. tuser[0] selects a target
// name character (0) or a directory byte (1); tuser[1] starts a new target
// name or a new scan. Load the target first, then stream directory entries.
// Output stream: one result per completed 32-byte entry, none after an end
// marker or a match until a new scan starts.
// Throughput: one request per cycle inside an entry. After the 32nd byte
// the input stalls while the back end works that entry: end, deleted and
// order-zero entries go straight to the result, a long-name part steps
// once per visited character, and a short entry takes an address and a
// data step per compare (long name and then 8.3 name, through the
// registered name RAM read). The result register loads when that work
// ends; the next request is taken in the cycle after it loads at the earliest.
// Reset clears the long-name store, target length and scan state at once.
// A stalled receiver holds the result; the front keeps taking bytes and
// only stalls once a second result would be needed.
// ----------------------------------------------------------------------------
module fat_directory_name_match import fdnm_pkg::*; #(
  parameter int TARGET_DEPTH    = TARGET_DEPTH_DEF,
  parameter int LONG_NAME_DEPTH = LONG_NAME_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [0] command, [1] first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // [1:0] status, [9:2] attributes,
                                 // [41:10] first_cluster, [73:42] file_size
);

  localparam int TLW = $clog2(TARGET_DEPTH + 1);
  localparam int EW  = $bits(entry_t);

  front_ctl_t     ctl;
  back_sts_t      sts;
  logic           push;
  entry_t         push_entry;
  logic           push_ready;
  logic           pop;
  logic           fifo_valid;
  logic [EW-1:0]  fifo_data;
  logic [TLW-1:0] tlen;

  fdnm_front #(.TARGET_DEPTH(TARGET_DEPTH), .TLW(TLW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .ctl       (ctl),
    .sts       (sts),
    .push      (push),
    .push_entry(push_entry),
    .push_ready(push_ready),
    .tlen      (tlen)
  );

  fdnm_fifo #(.WIDTH(EW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .push_ready(push_ready),
    .pop       (pop),
    .pop_valid (fifo_valid),
    .pop_data  (fifo_data)
  );

  fdnm_back #(
    .TARGET_DEPTH   (TARGET_DEPTH),
    .LONG_NAME_DEPTH(LONG_NAME_DEPTH),
    .TLW            (TLW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .fifo_valid(fifo_valid),
    .fifo_entry(entry_t'(fifo_data)),
    .pop       (pop),
    .tlen      (tlen),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

`ifndef SYNTHESIS
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> !fifo_valid)
    else $error("entry finished while another is queued");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !fifo_valid && !pop)
    else $error("new scan taken while an entry is in flight");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ready)
    else $error("entry pushed into a full queue");
  a_push_done: assert property (@(posedge clk) disable iff (rst)
    push |=> !s_tready)
    else $error("input not held while an entry is in flight");
`endif

endmodule

// ----- test/fdnm_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fdnm_checker
// Watches both streams of the directory name matcher. It keeps its own
// copy of the target name, entry buffer and long-name store, and predicts
// the result of every completed entry. Each result is compared field by
// field with the oldest expected one.
// ----------------------------------------------------------------------------
module fdnm_checker import fdnm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    status_t     status;
    logic [7:0]  attributes;
    logic [31:0] first_cluster;
    logic [31:0] file_size;
  } lookup_res_t;

  lookup_res_t expected_q[$];

  logic [7:0] entry_buf[32];
  int         entry_pos;
  logic [7:0] lfn_store[256];
  logic [7:0] target_name[128];
  int         target_len;
  bit         scan_done;

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function automatic bit equals_target(input logic [7:0] s[256], input int max);
    int ls;
    int lt;
    ls = 0;
    lt = 0;
    while (ls < max && s[ls] != 8'h00) ls++;
    while (lt < target_len && target_name[lt] != 8'h00) lt++;
    if (ls != lt) return 1'b0;
    for (int i = 0; i < ls; i++) begin
      if (lower(s[i]) != lower(target_name[i])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_lfn();
    foreach (lfn_store[i]) lfn_store[i] = 8'h00;
  endfunction

  function automatic void take_lfn_part();
    logic [7:0]  ord;
    int          pos;
    int          at;
    logic [15:0] ch;
    ord = entry_buf[0];
    if (ord[ORDER_LAST]) clear_lfn();
    if ((ord & ORDER_MASK) == 0) return;
    pos = ((ord & ORDER_MASK) - 1) * LFN_CHARS;
    for (int i = 0; i < LFN_CHARS; i++) begin
      at = (i < 5) ? 1 + 2 * i : (i < 11) ? 14 + 2 * (i - 5) : 28 + 2 * (i - 11);
      ch = {entry_buf[at + 1], entry_buf[at]};
      if (ch == 16'h0000 || ch == CHAR_UNUSED) return;
      if (pos < 255) begin
        lfn_store[pos] = (ch < ASCII_LIMIT) ? ch[7:0] : CHAR_QMARK;
        pos++;
      end
    end
  endfunction

  function automatic lookup_res_t close_entry();
    lookup_res_t r;
    logic [7:0]  text[256];
    int          n;
    bit          hit;
    r = '{STAT_SKIP, 8'h00, 32'h0, 32'h0};
    if (entry_buf[0] == ENTRY_END) begin
      r.status = STAT_END;
      scan_done = 1'b1;
      return r;
    end
    if (entry_buf[0] == ENTRY_DELETED) begin
      clear_lfn();
      return r;
    end
    if (entry_buf[11] == ATTR_LFN) begin
      take_lfn_part();
      return r;
    end
    foreach (text[i]) text[i] = 8'h00;
    n = 0;
    for (int i = 0; i < 8 && entry_buf[i] != CHAR_SPACE; i++) text[n++] = entry_buf[i];
    if (entry_buf[8] != CHAR_SPACE) begin
      text[n++] = CHAR_DOT;
      for (int i = 8; i < 11 && entry_buf[i] != CHAR_SPACE; i++) text[n++] = entry_buf[i];
    end
    hit = (lfn_store[0] != 8'h00 && equals_target(lfn_store, 256)) || equals_target(text, n);
    r.attributes    = entry_buf[11];
    r.first_cluster = {entry_buf[21], entry_buf[20], entry_buf[27], entry_buf[26]};
    r.file_size     = {entry_buf[31], entry_buf[30], entry_buf[29], entry_buf[28]};
    if (hit) begin
      r.status = STAT_MATCH;
      scan_done = 1'b1;
    end else begin
      r.status = STAT_NO_MATCH;
      clear_lfn();
    end
    return r;
  endfunction

  task automatic take_request(input logic cmd, input logic [7:0] b, input logic fst);
    if (!cmd) begin
      if (fst) target_len = 0;
      if (target_len < 128) target_name[target_len++] = b;
      return;
    end
    if (fst) begin
      entry_pos = 0;
      scan_done = 1'b0;
      clear_lfn();
    end else if (scan_done) begin
      return;
    end
    entry_buf[entry_pos] = b;
    if (entry_pos == 31) begin
      entry_pos = 0;
      expected_q.push_back(close_entry());
    end else begin
      entry_pos++;
    end
  endtask

  task automatic check_result(input logic [79:0] d);
    lookup_res_t e;
    if (expected_q.size() == 0) begin
      $error("unexpected result %h", d);
      fail_count++;
      return;
    end
    e = expected_q.pop_front();
    if (d[1:0] != e.status) begin
      $error("status: expected %0d, got %0d", e.status, d[1:0]);
      fail_count++;
    end
    if (d[9:2] != e.attributes) begin
      $error("attributes: expected %h, got %h", e.attributes, d[9:2]);
      fail_count++;
    end
    if (d[41:10] != e.first_cluster) begin
      $error("first_cluster: expected %h, got %h", e.first_cluster, d[41:10]);
      fail_count++;
    end
    if (d[73:42] != e.file_size) begin
      $error("file_size: expected %h, got %h", e.file_size, d[73:42]);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    entry_pos  = 0;
    target_len = 0;
    scan_done  = 1'b0;
    clear_lfn();
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) take_request(s_tuser[0], s_tdata, s_tuser[1]);
      if (m_tvalid && m_tready) check_result(m_tdata);
    end
    pending = expected_q.size();
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the directory name matcher with target names and directory scans:
// a few hand-built entries first, then random scans made mostly of long-name
// chains and 8.3 entries built from the target, mixed with deleted entries,
// end markers and raw noise. Both streams stall at random.
// ----------------------------------------------------------------------------
module tb;
  import fdnm_pkg::*;

  localparam int ITEMS_TOTAL = 1850;
  localparam int QUIET_AFTER = 1550;
  localparam int STALL_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;
  int          fail_count;
  int          pending;

  int          items;
  bit          quiet;
  int          idle_cycles;
  int          sink_hold;
  logic [7:0]  entry[32];
  logic [7:0]  target[$];
  logic [7:0]  dos_name[11];
  bit          has_short;

  fat_directory_name_match u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  fdnm_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  assign quiet = items >= QUIET_AFTER;

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b1;
      sink_hold <= 0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_tready  <= (sink_hold == 1);
    end else if (!quiet && $urandom_range(5) == 0) begin
      sink_hold <= $urandom_range(1, 5);
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic cmd, input logic [7:0] b, input logic fst);
    bit rdy;
    if (!quiet && $urandom_range(3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= {fst, cmd};
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    items++;
  endtask

  task automatic load_target();
    foreach (target[i]) send_request(1'b0, target[i], i == 0);
  endtask

  task automatic send_entry(input bit new_scan);
    foreach (entry[i]) send_request(1'b1, entry[i], new_scan && i == 0);
  endtask

  task automatic fill_random();
    foreach (entry[i]) entry[i] = 8'($urandom_range(255));
  endtask

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    c = 8'("A" + $urandom_range(25));
    return ($urandom_range(1) != 0) ? c + 8'h20 : c;
  endfunction

  // short entry: 11 name bytes, random attributes (never long-name), fields
  task automatic make_short(input logic [7:0] nm[11]);
    fill_random();
    for (int i = 0; i < 11; i++) entry[i] = nm[i];
    if (entry[11] == ATTR_LFN) entry[11] = 8'h20;
  endtask

  // one long-name part; idx counts 13-char slices of the target
  task automatic make_lfn_part(input logic [7:0] ord, input int idx);
    int          at;
    int          c;
    logic [15:0] ch;
    fill_random();
    entry[0]  = ord;
    entry[11] = ATTR_LFN;
    for (int i = 0; i < LFN_CHARS; i++) begin
      at = (i < 5) ? 1 + 2 * i : (i < 11) ? 14 + 2 * (i - 5) : 28 + 2 * (i - 11);
      c  = idx * LFN_CHARS + i;
      if (c < target.size()) begin
        ch = ($urandom_range(15) == 0) ? 16'(($urandom_range(255) << 8) | 8'h41)
                                       : {8'h00, target[c]};
      end else begin
        ch = (c == target.size()) ? 16'h0000 : CHAR_UNUSED;
      end
      {entry[at + 1], entry[at]} = ch;
    end
  endtask

  task automatic send_lfn_chain(input bit new_scan);
    int parts;
    parts = (target.size() + LFN_CHARS - 1) / LFN_CHARS;
    for (int k = parts; k >= 1; k--) begin
      make_lfn_part(8'(k) | ((k == parts) ? 8'h40 : 8'h00), k - 1);
      send_entry(new_scan && k == parts);
    end
  endtask

  task automatic random_target();
    int nlen;
    int elen;
    target.delete();
    has_short = 1'b0;
    case ($urandom_range(9))
      0: repeat (130) target.push_back(8'($urandom_range(255)));
      1, 2, 3, 4: begin
        nlen = $urandom_range(1, 8);
        elen = $urandom_range(0, 3);
        has_short = 1'b1;
        for (int i = 0; i < 11; i++) dos_name[i] = CHAR_SPACE;
        for (int i = 0; i < nlen; i++) begin
          dos_name[i] = name_char();
          target.push_back(dos_name[i] ^ (($urandom_range(1) != 0) ? 8'h20 : 8'h00));
        end
        if (elen > 0) target.push_back(CHAR_DOT);
        for (int i = 0; i < elen; i++) begin
          dos_name[8 + i] = name_char();
          target.push_back(dos_name[8 + i]);
        end
      end
      default: begin
        repeat ($urandom_range(1, 40)) target.push_back(name_char());
        if ($urandom_range(7) == 0) target[$urandom_range(target.size() - 1)] = 8'h00;
      end
    endcase
  endtask

  task automatic random_scan();
    bit         fresh;
    logic [7:0] nm[11];
    fresh = 1'b1;
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(9))
        0, 1, 2: send_lfn_chain(fresh);
        3, 4: begin
          if (has_short) nm = dos_name;
          else foreach (nm[i]) nm[i] = name_char();
          make_short(nm);
          send_entry(fresh);
        end
        5: begin
          foreach (nm[i]) nm[i] = ($urandom_range(3) == 0) ? CHAR_SPACE : name_char();
          make_short(nm);
          send_entry(fresh);
        end
        6: begin
          fill_random();
          entry[0] = ENTRY_DELETED;
          send_entry(fresh);
        end
        7: begin
          make_lfn_part(8'($urandom_range(255)), $urandom_range(3));
          send_entry(fresh);
        end
        default: begin
          fill_random();
          send_entry(fresh);
        end
      endcase
      fresh = 1'b0;
    end
    if ($urandom_range(2) == 0) begin
      fill_random();
      entry[0] = ENTRY_END;
      send_entry(fresh);
    end
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 8)) send_request(1'b1, 8'($urandom_range(255)), 1'b0);
    end
  endtask

  initial begin
    logic [7:0] nm[11];
    items    = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = 2'b00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 8.3 target, deleted entry, order-zero and non-ASCII
    // long-name parts, all-ones short entry, match, ignored tail, end marker
    target = '{"R", "e", "a", "D", "m", "E", ".", "t", "X", "t"};
    load_target();
    fill_random();
    entry[0] = ENTRY_DELETED;
    send_entry(1'b1);
    make_lfn_part(8'h40, 0);
    send_entry(1'b0);
    make_lfn_part(8'h41, 0);
    {entry[2], entry[1]} = 16'h00E9;
    send_entry(1'b0);
    foreach (entry[i]) entry[i] = 8'hFF;
    send_entry(1'b0);
    nm = '{"R", "E", "A", "D", "M", "E", " ", " ", "T", "X", "T"};
    make_short(nm);
    send_entry(1'b0);
    repeat (4) send_request(1'b1, 8'hFF, 1'b0);
    foreach (entry[i]) entry[i] = 8'h00;
    send_entry(1'b1);

    while (items < ITEMS_TOTAL) begin
      random_target();
      load_target();
      random_scan();
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- fat_directory_name_match.f -----
sv/fdnm_pkg.sv
sv/fdnm_ram.sv
sv/fdnm_fifo.sv
sv/fdnm_front.sv
sv/fdnm_back.sv
sv/fat_directory_name_match.sv
test/fdnm_checker.sv
test/tb.sv
